[hw/rtl/sftp_pkg.sv]
// shared types, constants and pattern tables for the sensor frame text parser
package sftp_pkg;

   localparam int MaxFrameBytesDefault = 128;
   localparam int Keys = 5;
   localparam logic [7:0] EndByte = 8'h1b;
   localparam logic [15:0] GapTimeoutReset = 16'd500;

   localparam logic [2:0] KIND_STATUS   = 3'd0;
   localparam logic [2:0] KIND_UPDATE   = 3'd1;
   localparam logic [2:0] KIND_NOTIFY   = 3'd2;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // per-key scan state handed from the scanner to the result stage
   typedef struct packed {
      logic [1:0]  phase;
      logic        negative;
      logic [15:0] magnitude;
   } key_state_type;

   typedef struct packed {
      logic        valid;
      logic        overflow;
      logic [7:0]  length;
      logic [2:0]  flags;
      key_state_type [Keys-1:0] keys;
   } frame_end_type;

   function automatic logic [7:0] hdr_char(input int unsigned which, input logic [3:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (which)
         0: case (pos)
               4'd0: c = "A"; 4'd1: c = "T"; 4'd2: c = "+"; 4'd3: c = "S";
               4'd4: c = "T"; 4'd5: c = "A"; 4'd6: c = "T"; 4'd7: c = "U";
               4'd8: c = "S"; 4'd9: c = "?"; default: c = 8'h00;
            endcase
         1: case (pos)
               4'd0: c = "A"; 4'd1: c = "T"; 4'd2: c = "+"; 4'd3: c = "U";
               4'd4: c = "P"; 4'd5: c = "D"; 4'd6: c = "A"; 4'd7: c = "T";
               4'd8: c = "E"; 4'd9: c = "="; default: c = 8'h00;
            endcase
         default: case (pos)
               4'd0: c = "A"; 4'd1: c = "T"; 4'd2: c = "+"; 4'd3: c = "N";
               4'd4: c = "O"; 4'd5: c = "T"; 4'd6: c = "I"; 4'd7: c = "F";
               4'd8: c = "Y"; 4'd9: c = "="; 4'd10: c = "o"; 4'd11: c = "k";
               default: c = 8'h00;
            endcase
      endcase
      return c;
   endfunction

   function automatic logic [3:0] key_len(input int unsigned k);
      case (k)
         0: return 4'd11;
         1: return 4'd14;
         default: return 4'd8;
      endcase
   endfunction

   function automatic logic [7:0] key_char(input int unsigned k, input int unsigned i);
      logic [8*14-1:0] s;
      int unsigned n;
      logic [7:0] c;
      case (k)
         0: begin s = 112'("\"humidity\":"); n = 11; end
         1: begin s = 112'("\"temperature\":"); n = 14; end
         2: begin s = 112'("\"light\":"); n = 8; end
         3: begin s = 112'("\"noise\":"); n = 8; end
         default: begin s = 112'("\"dusty\":"); n = 8; end
      endcase
      c = 8'h00;
      // text is right-justified, first char in the highest used byte
      if (i < n) c = s[8*(n-1-i) +: 8];
      return c;
   endfunction

   // longest pattern prefix that ends the matched text followed by c
   // (patterns start with a quote that recurs only as the closing quote,
   // so a restart can begin at the closing quote just matched)
   function automatic logic [3:0] key_next(input int unsigned k, input logic [3:0] p,
                                           input logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      if (key_char(k, int'(p)) == c) r = p + 4'd1;
      else if (p == key_len(k) - 4'd1 && c == key_char(k, 1)) r = 4'd2;
      else if (c == 8'h22) r = 4'd1;
      return r;
   endfunction

endpackage

[hw/rtl/sensor_frame_text_parser_top.sv]
// top level of the sensor frame text parser
// a closing byte's result item is registered in frame_end, then in the output register
// one item per cycle while req_tready is high; ticks and ordinary bytes give no result
// the output register plus one skid slot keep the input going while rsp is stalled
// reset: synchronous, active high; clears frame state, idle count saturates, timeout 500
module sensor_frame_text_parser_top
   import sftp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // frame_kind, humidity_present, humidity_value,
                                    // temperature_present, temperature_value, light_present,
                                    // light_percent, noise_present, noise_percent,
                                    // dust_present, dust_percent, zero fill
);

   logic [15:0]   timeout_ff;
   frame_end_type frame_end;
   logic [75:0]   result;
   logic [75:0]   out_ff, skid_ff;
   logic          out_v_ff, skid_v_ff;
   logic          pend_ff;

   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= GapTimeoutReset;
      else if (csr_wr_en) timeout_ff <= csr_wr_data;
   end

   // stop taking items only when both slots could end up full
   assign req_tready = !(skid_v_ff || (out_v_ff && pend_ff && !rsp_tready));

   sftp_scan #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_scan (
      .clock(clock), .reset(reset), .gap_timeout(timeout_ff),
      .in_valid(req_tvalid && req_tready), .in_cmd(req_tuser), .in_byte(req_tdata),
      .frame_end(frame_end));

   sftp_result u_result (.frame_end(frame_end), .result(result));

   always_ff @(posedge clock) begin
      logic ov, sv, take;
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         ov = out_v_ff && !rsp_tready;
         sv = skid_v_ff;
         take = frame_end.valid;
         if (!ov) begin
            if (sv) begin
               out_ff <= skid_ff; ov = 1'b1; sv = 1'b0;
               if (take) begin skid_ff <= result; sv = 1'b1; end
            end else if (take) begin
               out_ff <= result; ov = 1'b1;
            end
         end else if (take) begin
            skid_ff <= result; sv = 1'b1;
         end
         out_v_ff <= ov;
         skid_v_ff <= sv;
         pend_ff <= req_tvalid && req_tready && !req_tuser;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {4'd0, out_ff};

endmodule

[hw/rtl/sftp_scan.sv]
// per-byte frame scanner: timeout, header match, key search and decimal accumulate
module sftp_scan
   import sftp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [15:0]   gap_timeout,
   input  logic          in_valid,
   input  logic          in_cmd,
   input  logic [7:0]    in_byte,
   output frame_end_type frame_end
);

   logic [7:0]  length_ff, length_in;
   logic [15:0] idle_ff, idle_in;
   logic [3:0]  hpos_ff, hpos_in;
   logic [2:0]  flags_ff, flags_in;
   logic [3:0]  kprog_ff [Keys], kprog_in [Keys];
   key_state_type ks_ff [Keys], ks_in [Keys];
   frame_end_type end_in;

   always_comb begin
      logic        clr;
      logic [7:0]  len;
      logic [3:0]  hp;
      logic [2:0]  fl;
      logic [3:0]  kp [Keys];
      key_state_type ks [Keys];
      logic [19:0] m;
      logic        blank, digit, go;
      clr = 1'b0; len = 8'd0; hp = 4'd0; fl = 3'd0; m = 20'd0;
      blank = 1'b0; digit = 1'b0; go = 1'b0;
      for (int k = 0; k < Keys; k++) begin
         kp[k] = kprog_ff[k];
         ks[k] = ks_ff[k];
      end
      idle_in = idle_ff;
      length_in = length_ff;
      hpos_in = hpos_ff;
      flags_in = flags_ff;
      for (int k = 0; k < Keys; k++) begin
         kprog_in[k] = kprog_ff[k];
         ks_in[k] = ks_ff[k];
      end
      end_in = '0;
      if (in_valid && in_cmd) begin
         if (idle_ff != 16'hffff) idle_in = idle_ff + 16'd1;
      end else if (in_valid) begin
         clr = (idle_ff >= gap_timeout);
         idle_in = 16'd0;
         len = clr ? 8'd0 : length_ff;
         hp = clr ? 4'd0 : hpos_ff;
         fl = clr ? 3'd0 : flags_ff;
         for (int k = 0; k < Keys; k++) begin
            if (clr) begin
               kp[k] = 4'd0;
               ks[k] = '0;
            end
         end
         end_in.length = len;
         end_in.flags = fl;
         for (int k = 0; k < Keys; k++) end_in.keys[k] = ks[k];
         if (in_byte == EndByte || {1'b0, len} + 9'd1 > 9'(MAX_FRAME_BYTES)) begin
            end_in.valid = 1'b1;
            end_in.overflow = (in_byte != EndByte);
            length_in = 8'd0;
            hpos_in = 4'd0;
            flags_in = 3'd0;
            for (int k = 0; k < Keys; k++) begin
               kprog_in[k] = 4'd0;
               ks_in[k] = '0;
            end
         end else begin
            if (hp >= 4'd10 || hdr_char(0, hp) != in_byte) fl[0] = 1'b1;
            if (hp < 4'd10 && hdr_char(1, hp) != in_byte) fl[1] = 1'b1;
            if (hp >= 4'd12 || hdr_char(2, hp) != in_byte) fl[2] = 1'b1;
            flags_in = fl;
            hpos_in = (hp < 4'd15) ? hp + 4'd1 : hp;
            length_in = len + 8'd1;
            blank = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0d);
            digit = (in_byte >= "0" && in_byte <= "9");
            for (int k = 0; k < Keys; k++) begin
               go = 1'b0;
               case (ks[k].phase)
                  PH_SEARCH: begin
                     kp[k] = key_next(k, kp[k], in_byte);
                     if (kp[k] >= key_len(k)) begin
                        ks[k].phase = PH_SIGN;
                        kp[k] = 4'd0;
                     end
                  end
                  PH_SIGN: begin
                     if (!blank) begin
                        ks[k].phase = PH_DIGITS;
                        if (in_byte == "+" || in_byte == "-")
                           ks[k].negative = (in_byte == "-");
                        else go = 1'b1;
                     end
                  end
                  PH_DIGITS: go = 1'b1;
                  default: ;
               endcase
               if (go) begin
                  if (digit) begin
                     m = {4'd0, ks[k].magnitude} * 20'd10 + {12'd0, in_byte - 8'h30};
                     ks[k].magnitude = (m > 20'd32768) ? 16'd32768 : m[15:0];
                  end else ks[k].phase = PH_DONE;
               end
               kprog_in[k] = kp[k];
               ks_in[k] = ks[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= 16'hffff;
         length_ff <= 8'd0;
         hpos_ff <= 4'd0;
         flags_ff <= 3'd0;
         for (int k = 0; k < Keys; k++) begin
            kprog_ff[k] <= 4'd0;
            ks_ff[k] <= '0;
         end
         frame_end <= '0;
      end else begin
         idle_ff <= idle_in;
         length_ff <= length_in;
         hpos_ff <= hpos_in;
         flags_ff <= flags_in;
         for (int k = 0; k < Keys; k++) begin
            kprog_ff[k] <= kprog_in[k];
            ks_ff[k] <= ks_in[k];
         end
         frame_end <= end_in;
      end
   end

endmodule

[hw/rtl/sftp_result.sv]
// classify the ended frame and scale the key values into a result item
module sftp_result
   import sftp_pkg::*;
(
   input  frame_end_type frame_end,
   output logic [75:0]   result
);

   // signed divide by 9 truncating toward zero, |x| below 2^22, by reciprocal multiply
   function automatic logic signed [23:0] div9(input logic signed [23:0] x);
      logic [21:0] a;
      logic [44:0] p;
      logic [23:0] q;
      a = x[23] ? 22'(-x) : x[21:0];
      p = 45'(a) * 45'd7456541;
      q = {5'd0, p[44:26]};
      return x[23] ? -$signed(q) : $signed(q);
   endfunction

   always_comb begin
      logic [2:0]  kind;
      logic signed [16:0] v;
      logic signed [23:0] t;
      logic [15:0] hv, tv;
      logic [7:0]  lp, dp;
      logic [19:0] np;
      logic [4:0]  pres;
      kind = KIND_UNKNOWN; hv = '0; tv = '0; lp = '0; dp = '0; np = '0; pres = '0;
      v = '0; t = '0;
      if (frame_end.overflow) kind = KIND_OVERFLOW;
      else if (!frame_end.flags[0] && frame_end.length == 8'd10) kind = KIND_STATUS;
      else if (!frame_end.flags[1] && frame_end.length >= 8'd10) kind = KIND_UPDATE;
      else if (!frame_end.flags[2] && frame_end.length == 8'd12) kind = KIND_NOTIFY;
      if (kind == KIND_UPDATE) begin
         for (int k = 0; k < Keys; k++) begin
            if (frame_end.keys[k].negative) v = -$signed({1'b0, frame_end.keys[k].magnitude});
            else if (frame_end.keys[k].magnitude > 16'd32767) v = 17'sd32767;
            else v = $signed({1'b0, frame_end.keys[k].magnitude});
            if (frame_end.keys[k].phase != PH_SEARCH && v != -17'sd1) begin
               pres[k] = 1'b1;
               case (k)
                  0: hv = v[15:0];
                  1: tv = v[15:0];
                  3: begin
                     t = div9((24'(v) - 24'sd1) * 24'sd100);
                     np = t[19:0];
                  end
                  default: begin
                     t = div9((24'sd10 - 24'(v)) * 24'sd100);
                     if (k == 2) lp = t[7:0]; else dp = t[7:0];
                  end
               endcase
            end
         end
      end
      result = {dp, pres[4], np, pres[3], lp, pres[2], tv, pres[1], hv, pres[0], kind};
   end

endmodule

[hw/rtl/sftp_checker.sv]
// port-level assertions for the sensor frame text parser
module sftp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp held");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd4) else $error("bad kind");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd1 |-> rsp_tdata[75:3] == '0) else $error("fields");
   a_tick: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 !rsp_tvalid && !$past(req_tvalid && req_tready && !req_tuser, 2)
      |-> !rsp_tvalid) else $error("spurious");
endmodule

bind sensor_frame_text_parser_top sftp_checker u_checker (.*);

[tb/sensor_frame_text_parser_top_test.sv]
// testbench for the sensor frame text parser: directed frames, gap and overflow cases, random frames
`timescale 1ns / 100ps

module sensor_frame_text_parser_top_test;
   import sftp_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int NUM_FIELDS = 11;
   localparam int FIELD_OFF[NUM_FIELDS] = '{0, 3, 4, 20, 21, 37, 38, 46, 47, 67, 68};
   localparam int FIELD_W[NUM_FIELDS] = '{3, 1, 16, 1, 16, 1, 8, 1, 20, 1, 8};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   sensor_frame_text_parser_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser state mirror
   string      hdr_text[3] = '{"AT+STATUS?", "AT+UPDATE=", "AT+NOTIFY=ok"};
   string      key_text[Keys] = '{"\"humidity\":", "\"temperature\":", "\"light\":",
                                  "\"noise\":", "\"dusty\":"};
   int         gap_limit;
   int         frame_len;
   int         idle_count;
   int         hdr_pos;
   logic [2:0] hdr_dead;
   int         key_pos[Keys];
   logic [1:0] key_ph[Keys];
   bit         key_neg[Keys];
   int         key_mag[Keys];

   logic [79:0] expected_frames[$];
   logic [7:0]  frame_bytes[$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;
   int          stall_left = 0;

   function automatic void clear_frame_state();
      frame_len = 0;
      hdr_pos = 0;
      hdr_dead = '0;
      for (int k = 0; k < Keys; k++) begin
         key_pos[k] = 0;
         key_ph[k] = PH_SEARCH;
         key_neg[k] = 1'b0;
         key_mag[k] = 0;
      end
   endfunction

   // longest key prefix that ends the matched text followed by c
   function automatic int next_match(int k, int p, logic [7:0] c);
      bit same;
      if (key_text[k][p] == c) return p + 1;
      for (int n = p; n >= 1; n--) begin
         same = (key_text[k][n-1] == c);
         for (int i = 0; same && i + 1 < n; i++)
            if (key_text[k][i] != key_text[k][p-n+1+i]) same = 1'b0;
         if (same) return n;
      end
      return 0;
   endfunction

   function automatic void scan_key(int k, logic [7:0] b);
      bit digit_step;
      digit_step = (key_ph[k] == PH_DIGITS);
      if (key_ph[k] == PH_SEARCH) begin
         key_pos[k] = next_match(k, key_pos[k], b);
         if (key_pos[k] >= key_text[k].len()) begin
            key_ph[k] = PH_SIGN;
            key_pos[k] = 0;
         end
      end else if (key_ph[k] == PH_SIGN) begin
         if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d)) begin
         end else if (b == "+" || b == "-") begin
            key_neg[k] = (b == "-");
            key_ph[k] = PH_DIGITS;
         end else begin
            key_ph[k] = PH_DIGITS;
            digit_step = 1'b1;
         end
      end
      if (digit_step) begin
         if (b >= "0" && b <= "9") begin
            key_mag[k] = key_mag[k] * 10 + (b - "0");
            if (key_mag[k] > 32768) key_mag[k] = 32768;
         end else key_ph[k] = PH_DONE;
      end
   endfunction

   function automatic logic [79:0] pack_frame(int vals[NUM_FIELDS]);
      logic [79:0] r;
      r = '0;
      for (int i = 0; i < NUM_FIELDS; i++)
         r |= 80'((vals[i] & ((1 << FIELD_W[i]) - 1))) << FIELD_OFF[i];
      return r;
   endfunction

   function automatic void close_frame();
      int vals[NUM_FIELDS];
      int v;
      logic [2:0] kind;
      vals = '{default: 0};
      kind = KIND_UNKNOWN;
      if (!hdr_dead[0] && frame_len == 10) kind = KIND_STATUS;
      else if (!hdr_dead[1] && frame_len >= 10) kind = KIND_UPDATE;
      else if (!hdr_dead[2] && frame_len == 12) kind = KIND_NOTIFY;
      vals[0] = kind;
      if (kind == KIND_UPDATE)
         for (int k = 0; k < Keys; k++) begin
            if (key_ph[k] == PH_SEARCH) continue;
            v = key_neg[k] ? -key_mag[k] : (key_mag[k] > 32767 ? 32767 : key_mag[k]);
            if (v == -1) continue;
            vals[1+2*k] = 1;
            if (k <= 1) vals[2+2*k] = v;
            else if (k == 3) vals[2+2*k] = ((v - 1) * 100) / 9;
            else vals[2+2*k] = ((10 - v) * 100) / 9;
         end
      expected_frames.push_back(pack_frame(vals));
   endfunction

   function automatic void predict_item(bit cmd, logic [7:0] b);
      int vals[NUM_FIELDS];
      if (cmd) begin
         if (idle_count != 65535) idle_count++;
         return;
      end
      if (idle_count >= gap_limit) clear_frame_state();
      idle_count = 0;
      if (b == EndByte) begin
         close_frame();
         clear_frame_state();
         return;
      end
      if (frame_len + 1 > MaxFrameBytesDefault) begin
         vals = '{default: 0};
         vals[0] = KIND_OVERFLOW;
         expected_frames.push_back(pack_frame(vals));
         clear_frame_state();
         return;
      end
      if (hdr_pos >= 10 || hdr_text[0][hdr_pos] != b) hdr_dead[0] = 1'b1;
      if (hdr_pos < 10 && hdr_text[1][hdr_pos] != b) hdr_dead[1] = 1'b1;
      if (hdr_pos >= 12 || hdr_text[2][hdr_pos] != b) hdr_dead[2] = 1'b1;
      if (hdr_pos < 15) hdr_pos++;
      for (int k = 0; k < Keys; k++) scan_key(k, b);
      frame_len++;
   endfunction

   // result checking
   always @(posedge clock) begin
      logic [79:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            for (int i = 0; i < NUM_FIELDS; i++)
               if (((rsp_tdata >> FIELD_OFF[i]) & ((80'd1 << FIELD_W[i]) - 1)) !=
                   ((want >> FIELD_OFF[i]) & ((80'd1 << FIELD_W[i]) - 1))) begin
                  $display("%0t: field %0d expected %h actual %h", $time, i,
                           (want >> FIELD_OFF[i]) & ((80'd1 << FIELD_W[i]) - 1),
                           (rsp_tdata >> FIELD_OFF[i]) & ((80'd1 << FIELD_W[i]) - 1));
                  errors++;
               end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(bit cmd, logic [7:0] b);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predict_item(cmd, b);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(1'b1, 8'($urandom));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
   endtask

   task automatic set_gap_timeout(logic [15:0] v);
      wait_drain();
      repeat (6) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gap_limit = v;
   endtask

   function automatic string number_text();
      string s;
      case ($urandom_range(0, 11))
         0: s = "-1";
         1: s = "0";
         2: s = "32767";
         3: s = "32768";
         4: s = "-32768";
         5: s = "-32769";
         6: s = "9999999";
         7: s = "";
         8: s = $sformatf("-%0d", $urandom_range(0, 30));
         9: s = $sformatf("+%0d", $urandom_range(0, 30));
         10: s = $sformatf("%0d", $urandom_range(0, 40000));
         default: s = $sformatf("%0d", $urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 5))
         0: s = {" ", s};
         1: s = {"\t ", s};
         default: ;
      endcase
      return s;
   endfunction

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   // one frame of random content, mostly well formed
   task automatic build_frame();
      int k;
      string cut;
      frame_bytes.delete();
      case ($urandom_range(0, 11))
         0: push_text("AT+STATUS?");
         1: push_text("AT+NOTIFY=ok");
         2: repeat ($urandom_range(0, 20)) frame_bytes.push_back(8'($urandom));
         3: push_text("AT+STATUS?x");
         4: push_text("AT+UPDATE");
         5: repeat ($urandom_range(129, 140)) frame_bytes.push_back(8'($urandom_range(32, 126)));
         default: begin
            push_text("AT+UPDATE={");
            repeat ($urandom_range(0, 7)) begin
               k = $urandom_range(0, Keys - 1);
               if ($urandom_range(0, 7) == 0) begin
                  cut = key_text[k].substr(0, $urandom_range(0, key_text[k].len() - 2));
                  push_text(cut);
               end else push_text({key_text[k], number_text()});
               push_text($urandom_range(0, 5) == 0 ? " x," : ",");
            end
            push_text("}");
         end
      endcase
      frame_bytes.push_back(EndByte);
   endtask

   task automatic test_headers();
      send_text("AT+STATUS?\x1b");
      send_text("AT+NOTIFY=ok\x1b");
      send_text("AT+UPDATE=\x1b");
      send_text("AT+NOTIFY=o\x1b");
      send_text("\x1b");
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hff);
      send_item(1'b0, EndByte);
   endtask

   task automatic test_values();
      send_text({"AT+UPDATE={\"humidity\":32768,\"temperature\":-32769,\"light\": -1,",
                 "\"noise\":-32768,\"dusty\":+10}\x1b"});
      send_text({"AT+UPDATE=\"humidity\":\t-0,\"temperature\":x,\"light\":32767,",
                 "\"noise\":32767,\"dusty\":-32768,\"humidity\":5\x1b"});
      send_text("AT+UPDATE=\"\"light\":-1,\"noise\":0\x1b");
      send_text("AT+UPDATE=\"light\"light\":7,\"noise\"\"noise\":3\x1b");
   endtask

   task automatic test_gap_timeout();
      set_gap_timeout(16'd20);
      send_text("AT+STATUS");
      send_ticks(19);
      send_text("?\x1b");
      send_text("AT+STATUS");
      send_ticks(20);
      send_text("?\x1b");
      set_gap_timeout(16'd1);
      send_text("AT+NOT");
      send_ticks(1);
      send_text("IFY=ok\x1b");
      set_gap_timeout(16'hffff);
      send_text("AT+NOTIFY=");
      send_ticks(40);
      send_text("ok\x1b");
   endtask

   task automatic test_overflow();
      repeat (128) send_item(1'b0, "a");
      send_text("bAT+STATUS?\x1b");
   endtask

   task automatic test_random(int n_items, logic [15:0] timeout);
      int sent;
      set_gap_timeout(timeout);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 19) == 0) wait_drain();
         build_frame();
         foreach (frame_bytes[i]) begin
            if ($urandom_range(0, 29) == 0) send_ticks($urandom_range(1, 3));
            send_item(1'b0, frame_bytes[i]);
         end
         sent += frame_bytes.size();
      end
   endtask

   initial begin
      gap_limit = GapTimeoutReset;
      idle_count = 65535;
      clear_frame_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_headers();
      test_values();
      test_gap_timeout();
      test_overflow();
      test_random(200, 16'd3);
      test_random(150, 16'd500);
      quiet = 1'b1;
      test_random(150, 16'd8);
      wait_drain();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
